// ----- rtl/assert_macros.svh -----
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ASSERT_CLK_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/vna_pkg.sv -----
`timescale 1ns / 1ps
package vna_pkg;
  localparam int VertexCountDefault = 1024;
  localparam int IndexWidth = 10;
  localparam int CoordWidth = 16;
  localparam int NormWidth = 16;

  typedef enum logic [1:0] {
    CMD_WRITE_VERTEX = 2'd0,
    CMD_ADD_FACE     = 2'd1,
    CMD_READ_NORMAL  = 2'd2,
    CMD_NONE         = 2'd3
  } cmd_t;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_IGNORED = 1'b1;

  // request from the sequencer to the normalizer
  typedef struct packed {
    logic        start;
    logic [35:0] vx;
    logic [35:0] vy;
    logic [35:0] vz;
  } norm_req_t;

  // answer from the normalizer
  typedef struct packed {
    logic                  done;
    logic                  zero;
    logic [NormWidth-1:0]  nx;
    logic [NormWidth-1:0]  ny;
    logic [NormWidth-1:0]  nz;
  } norm_rsp_t;
endpackage

// ----- rtl/vna_normalize.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vna_normalize
  import vna_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  norm_req_t req,
  output norm_rsp_t rsp
);
  typedef enum logic [2:0] {
    N_IDLE, N_SCALE, N_SQ, N_SQRT, N_DIV, N_DONE
  } nstate_t;

  nstate_t      state;
  logic [35:0]  mag [3];
  logic [2:0]   neg;
  logic [1:0]   sel;
  logic [63:0]  sum;
  logic [63:0]  rem;
  logic [63:0]  root;
  logic [63:0]  bitv;
  logic [32:0]  len;
  logic [47:0]  dnum;
  logic [47:0]  dquo;
  logic [33:0]  drem;
  logic [5:0]   cnt;
  logic [15:0]  res [3];

  logic [35:0] mx;
  logic [63:0] sq;
  logic [63:0] trial;
  logic [34:0] dtry;
  logic [33:0] dshift;

  function automatic logic [35:0] absv(input logic [35:0] v);
    return v[35] ? (36'd0 - v) : v;
  endfunction

  always_comb begin
    mx = mag[0];
    if (mag[1] > mx) mx = mag[1];
    if (mag[2] > mx) mx = mag[2];
    // scaled magnitudes are below 2^31 here
    sq = {33'd0, mag[sel][30:0]} * {33'd0, mag[sel][30:0]};
    trial = root + bitv;
    dshift = {drem[32:0], dnum[47]};
    dtry = {1'b0, dshift} - {2'b0, len};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      unique case (state)
        N_IDLE: begin
          if (req.start) begin
            mag[0] <= absv(req.vx);
            mag[1] <= absv(req.vy);
            mag[2] <= absv(req.vz);
            neg <= {req.vz[35], req.vy[35], req.vx[35]};
            state <= N_SCALE;
          end
        end
        N_SCALE: begin
          if (mx == '0) begin
            rsp.zero <= 1'b1;
            rsp.done <= 1'b1;
            state <= N_IDLE;
          end else if (mx < 36'h040000000) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
          end else if (mx >= 36'h080000000) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
          end else begin
            sel <= 2'd0;
            sum <= '0;
            state <= N_SQ;
          end
        end
        N_SQ: begin
          sum <= sum + sq;
          if (sel == 2'd2) begin
            state <= N_SQRT;
            root <= '0;
            bitv <= 64'h4000000000000000;
          end else begin
            sel <= sel + 2'd1;
          end
          if (sel == 2'd0) rem <= sq;
          else rem <= sum + sq;
        end
        N_SQRT: begin
          if (bitv == '0) begin
            len <= root[32:0];
            sel <= 2'd0;
            state <= N_DIV;
            cnt <= '0;
            dnum <= {2'd0, mag[0][31:0], 14'd0} + {15'd0, root[33:1]};
            drem <= '0;
          end else begin
            if (rem >= trial) begin
              rem <= rem - trial;
              root <= (root >> 1) + bitv;
            end else begin
              root <= root >> 1;
            end
            bitv <= bitv >> 2;
          end
        end
        N_DIV: begin
          // restoring division, one quotient bit per cycle
          if (!dtry[34]) begin
            drem <= dtry[33:0];
            dquo <= {dquo[46:0], 1'b1};
          end else begin
            drem <= dshift;
            dquo <= {dquo[46:0], 1'b0};
          end
          dnum <= dnum << 1;
          if (cnt == 6'd47) begin
            state <= N_DONE;
          end
          cnt <= cnt + 6'd1;
        end
        N_DONE: begin
          res[sel] <= neg[sel] ? (16'd0 - dquo[15:0]) : dquo[15:0];
          if (sel == 2'd2) begin
            rsp.nx <= res[0];
            rsp.ny <= res[1];
            rsp.nz <= neg[2] ? (16'd0 - dquo[15:0]) : dquo[15:0];
            rsp.zero <= 1'b0;
            rsp.done <= 1'b1;
            state <= N_IDLE;
          end else begin
            sel <= sel + 2'd1;
            cnt <= '0;
            drem <= '0;
            dnum <= {2'd0, mag[sel + 2'd1][31:0], 14'd0} + {15'd0, len[32:1]};
            state <= N_DIV;
          end
        end
        default: state <= N_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_done_pulse, clk, rst, rsp.done |=> !rsp.done, "done longer than one cycle")
  `ASSERT_CLK(a_start_idle, clk, rst, rsp.done |=> state == N_IDLE, "normalizer not idle")
endmodule

// ----- rtl/vertex_normal_accumulator.sv -----
`timescale 1ns / 1ps
// throughput: one word at a time; a face runs up to four normalizations in one
// shared unit (scaling, 32-step square root, three 48-step divides each)
// reset: after rst a clearing pass writes zero to every entry of the normal
// store; no word is taken until it ends
`include "assert_macros.svh"
module vertex_normal_accumulator
  import vna_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // command[1:0], vertex_index[11:2], coord_x[27:12], coord_y[43:28],
  // coord_z[59:44], face_vertex_a[69:60], face_vertex_b[79:70], face_vertex_c[89:80]
  input  logic [95:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[0], normal_x[16:1], normal_y[32:17], normal_z[48:33]
  output logic [55:0] m_tdata
);
  localparam int VERTEX_COUNT = VertexCountDefault;
  localparam int AW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RDV0, S_RDV1, S_RDV2, S_CROSS, S_CROSS2, S_FACE_NORM,
    S_CRD, S_CRD2, S_CSUM, S_CWRITE, S_READ, S_READ2, S_OUT
  } state_t;

  state_t state;
  logic [47:0] vmem [VERTEX_COUNT];
  logic [47:0] nmem [VERTEX_COUNT];
  logic [47:0] vrd, nrd;
  logic [AW-1:0] vaddr, naddr, clr;
  logic nwe;
  logic [47:0] nwd;

  logic [1:0]  cmd;
  logic [9:0]  cidx [3];
  logic [9:0]  vidx;
  logic signed [16:0] e1 [3];
  logic signed [16:0] e2 [3];
  logic signed [16:0] pa [3];
  logic signed [34:0] p0, p1, p2, p3, p4, p5;
  logic [1:0]  corner;
  logic [15:0] fn [3];
  logic        status;
  logic [15:0] ox, oy, oz;
  norm_req_t   nreq;
  norm_rsp_t   nrsp;

  logic idx_ok, face_ok;
  assign idx_ok = {22'd0, s_tdata[11:2]} < VERTEX_COUNT;
  assign face_ok = ({22'd0, s_tdata[69:60]} < VERTEX_COUNT) &&
                   ({22'd0, s_tdata[79:70]} < VERTEX_COUNT) &&
                   ({22'd0, s_tdata[89:80]} < VERTEX_COUNT);

  vna_normalize u_norm (.clk(clk), .rst(rst), .req(nreq), .rsp(nrsp));

  always_ff @(posedge clk) begin
    vrd <= vmem[vaddr];
    if (state == S_IDLE && s_tvalid && s_tready &&
        s_tdata[1:0] == CMD_WRITE_VERTEX && idx_ok)
      vmem[s_tdata[AW+1:2]] <= s_tdata[59:12];
  end

  always_ff @(posedge clk) begin
    nrd <= nmem[naddr];
    if (nwe) nmem[naddr] <= nwd;
  end

  assign s_tready = (state == S_IDLE) && !m_tvalid;
  assign m_tdata = {7'd0, oz, oy, ox, status};

  always_comb begin
    nwe = 1'b0;
    nwd = '0;
    naddr = vidx[AW-1:0];
    if (state == S_CLEAR) begin
      nwe = 1'b1;
      naddr = clr;
    end else if (state == S_CRD || state == S_CRD2 || state == S_CSUM ||
                 state == S_CWRITE) begin
      naddr = cidx[corner][AW-1:0];
      if (state == S_CWRITE && nrsp.done) begin
        nwe = 1'b1;
        nwd = nrsp.zero ? 48'd0 : {nrsp.nz, nrsp.ny, nrsp.nx};
      end else if (state == S_CSUM && nrd == '0) begin
        nwe = 1'b1;
        nwd = {fn[2], fn[1], fn[0]};
      end
    end
  end

  always_comb begin
    vaddr = cidx[0][AW-1:0];
    if (state == S_RDV1) vaddr = cidx[1][AW-1:0];
    else if (state == S_RDV2) vaddr = cidx[2][AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      m_tvalid <= 1'b0;
      nreq.start <= 1'b0;
      corner <= 2'd0;
    end else begin
      nreq.start <= 1'b0;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if ({1'b0, clr} == (AW+1)'(VERTEX_COUNT - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            cmd <= s_tdata[1:0];
            vidx <= s_tdata[11:2];
            cidx[0] <= s_tdata[69:60];
            cidx[1] <= s_tdata[79:70];
            cidx[2] <= s_tdata[89:80];
            status <= STATUS_OK;
            ox <= '0; oy <= '0; oz <= '0;
            unique case (s_tdata[1:0])
              CMD_ADD_FACE: begin
                if (face_ok) state <= S_RDV0;
                else begin
                  status <= STATUS_IGNORED;
                  state <= S_OUT;
                end
              end
              CMD_READ_NORMAL: state <= idx_ok ? S_READ : S_OUT;
              default: state <= S_OUT;
            endcase
          end
        end
        S_RDV0: state <= S_RDV1;
        S_RDV1: begin
          for (int i = 0; i < 3; i++) pa[i] <= 17'(signed'(vrd[16*i +: 16]));
          state <= S_RDV2;
        end
        S_RDV2: begin
          for (int i = 0; i < 3; i++) e1[i] <= 17'(signed'(vrd[16*i +: 16])) - pa[i];
          state <= S_CROSS;
        end
        S_CROSS: begin
          for (int i = 0; i < 3; i++) e2[i] <= 17'(signed'(vrd[16*i +: 16])) - pa[i];
          state <= S_CROSS2;
        end
        S_CROSS2: begin
          p0 <= 35'(e1[1] * e2[2]); p1 <= 35'(e1[2] * e2[1]);
          p2 <= 35'(e1[2] * e2[0]); p3 <= 35'(e1[0] * e2[2]);
          p4 <= 35'(e1[0] * e2[1]); p5 <= 35'(e1[1] * e2[0]);
          state <= S_FACE_NORM;
        end
        S_FACE_NORM: begin
          if (!nreq.start && !nrsp.done && cmd == CMD_ADD_FACE && status == STATUS_OK
              && corner != 2'd3) begin
            nreq.start <= 1'b1;
            nreq.vx <= 36'(p0) - 36'(p1);
            nreq.vy <= 36'(p2) - 36'(p3);
            nreq.vz <= 36'(p4) - 36'(p5);
            corner <= 2'd3;
          end
          if (nrsp.done) begin
            if (nrsp.zero) begin
              status <= STATUS_IGNORED;
              state <= S_OUT;
            end else begin
              fn[0] <= nrsp.nx; fn[1] <= nrsp.ny; fn[2] <= nrsp.nz;
              ox <= nrsp.nx; oy <= nrsp.ny; oz <= nrsp.nz;
              corner <= 2'd0;
              state <= S_CRD;
            end
          end
        end
        S_CRD: state <= S_CRD2;
        S_CRD2: state <= S_CSUM;
        S_CSUM: begin
          if (nrd == '0) begin
            if (corner == 2'd2) state <= S_OUT;
            else begin
              corner <= corner + 2'd1;
              state <= S_CRD;
            end
          end else begin
            nreq.start <= 1'b1;
            nreq.vx <= 36'(signed'(nrd[15:0])) + 36'(signed'(fn[0]));
            nreq.vy <= 36'(signed'(nrd[31:16])) + 36'(signed'(fn[1]));
            nreq.vz <= 36'(signed'(nrd[47:32])) + 36'(signed'(fn[2]));
            state <= S_CWRITE;
          end
        end
        S_CWRITE: begin
          if (nrsp.done) begin
            if (corner == 2'd2) state <= S_OUT;
            else begin
              corner <= corner + 2'd1;
              state <= S_CRD;
            end
          end
        end
        S_READ: state <= S_READ2;
        S_READ2: begin
          ox <= nrd[15:0]; oy <= nrd[31:16]; oz <= nrd[47:32];
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid) begin
            m_tvalid <= 1'b1;
            corner <= 2'd0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_no_take_busy, clk, rst, s_tready |-> state == S_IDLE, "ready while busy")
  `ASSERT_CLK(a_out_from_out, clk, rst, $rose(m_tvalid) |-> $past(state) == S_OUT, "stray result")
  `ASSERT_CLK(a_clear_no_take, clk, rst, state == S_CLEAR |-> !s_tready, "take during clear")
endmodule

// ----- verif/tb_vertex_normal_accumulator.sv -----
`timescale 1ns / 1ps
module tb_vertex_normal_accumulator;
  import vna_pkg::*;

  localparam int NVERT = 1024;
  localparam int RANDOM_WORDS = 430;
  localparam int QUIET_FROM = 380;
  localparam int STALL_LIMIT = 6000;

  typedef struct {
    logic        status;
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
  } normal_word_t;

  class normal_scoreboard;
    int vert_x[NVERT];
    int vert_y[NVERT];
    int vert_z[NVERT];
    int norm_x[NVERT];
    int norm_y[NVERT];
    int norm_z[NVERT];
    normal_word_t pending[$];
    int errors;

    function new();
      errors = 0;
      for (int i = 0; i < NVERT; i++) begin
        norm_x[i] = 0; norm_y[i] = 0; norm_z[i] = 0;
        vert_x[i] = 0; vert_y[i] = 0; vert_z[i] = 0;
      end
    endfunction

    function longint unsigned int_sqrt(longint unsigned s);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (s >= res + bitv) begin
          s = s - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    // unit vector in q1.14, returns 0 for a zero vector
    function bit unit_vec(longint ax, longint ay, longint az,
                          output int ox, output int oy, output int oz);
      longint unsigned mx, my, mz, mm, s, len, qx, qy, qz;
      mx = ax < 0 ? -ax : ax;
      my = ay < 0 ? -ay : ay;
      mz = az < 0 ? -az : az;
      mm = mx;
      if (my > mm) mm = my;
      if (mz > mm) mm = mz;
      ox = 0; oy = 0; oz = 0;
      if (mm == 0) return 0;
      while (mm < (64'd1 << 30)) begin
        mx = mx << 1; my = my << 1; mz = mz << 1; mm = mm << 1;
      end
      while (mm >= (64'd1 << 31)) begin
        mx = mx >> 1; my = my >> 1; mz = mz >> 1; mm = mm >> 1;
      end
      s = mx * mx + my * my + mz * mz;
      len = int_sqrt(s);
      qx = (mx * 16384 + len / 2) / len;
      qy = (my * 16384 + len / 2) / len;
      qz = (mz * 16384 + len / 2) / len;
      ox = ax < 0 ? -int'(qx) : int'(qx);
      oy = ay < 0 ? -int'(qy) : int'(qy);
      oz = az < 0 ? -int'(qz) : int'(qz);
      return 1;
    endfunction

    function void note_word(logic [95:0] d);
      normal_word_t e;
      int idx, fx, fy, fz, sx, sy, sz;
      int corner[3];
      longint e1x, e1y, e1z, e2x, e2y, e2z, cx, cy, cz;
      idx = int'(d[11:2]);
      e.status = STATUS_OK;
      e.nx = 0; e.ny = 0; e.nz = 0;
      case (cmd_t'(d[1:0]))
        CMD_WRITE_VERTEX: begin
          vert_x[idx] = $signed(d[27:12]);
          vert_y[idx] = $signed(d[43:28]);
          vert_z[idx] = $signed(d[59:44]);
        end
        CMD_ADD_FACE: begin
          corner[0] = int'(d[69:60]);
          corner[1] = int'(d[79:70]);
          corner[2] = int'(d[89:80]);
          e1x = vert_x[corner[1]] - vert_x[corner[0]];
          e1y = vert_y[corner[1]] - vert_y[corner[0]];
          e1z = vert_z[corner[1]] - vert_z[corner[0]];
          e2x = vert_x[corner[2]] - vert_x[corner[0]];
          e2y = vert_y[corner[2]] - vert_y[corner[0]];
          e2z = vert_z[corner[2]] - vert_z[corner[0]];
          cx = e1y * e2z - e1z * e2y;
          cy = e1z * e2x - e1x * e2z;
          cz = e1x * e2y - e1y * e2x;
          if (!unit_vec(cx, cy, cz, fx, fy, fz)) begin
            e.status = STATUS_IGNORED;
          end else begin
            for (int j = 0; j < 3; j++) begin
              idx = corner[j];
              if (norm_x[idx] == 0 && norm_y[idx] == 0 && norm_z[idx] == 0) begin
                norm_x[idx] = fx; norm_y[idx] = fy; norm_z[idx] = fz;
              end else begin
                // zero sum leaves the outputs at zero
                void'(unit_vec(norm_x[idx] + fx, norm_y[idx] + fy, norm_z[idx] + fz,
                               sx, sy, sz));
                norm_x[idx] = sx; norm_y[idx] = sy; norm_z[idx] = sz;
              end
            end
            e.nx = 16'(fx); e.ny = 16'(fy); e.nz = 16'(fz);
          end
        end
        CMD_READ_NORMAL: begin
          e.nx = 16'(norm_x[idx]); e.ny = 16'(norm_y[idx]); e.nz = 16'(norm_z[idx]);
        end
        default: ;
      endcase
      pending.push_back(e);
    endfunction

    function void check_word(logic [55:0] r);
      normal_word_t e;
      if (pending.size() == 0) begin
        $error("result word with nothing expected: %h", r);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (r[0] !== e.status) begin
        $error("status expected %0d got %0d", e.status, r[0]);
        errors++;
      end
      if (r[16:1] !== e.nx) begin
        $error("normal_x expected %0d got %0d", $signed(e.nx), $signed(r[16:1]));
        errors++;
      end
      if (r[32:17] !== e.ny) begin
        $error("normal_y expected %0d got %0d", $signed(e.ny), $signed(r[32:17]));
        errors++;
      end
      if (r[48:33] !== e.nz) begin
        $error("normal_z expected %0d got %0d", $signed(e.nz), $signed(r[48:33]));
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [95:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;

  normal_scoreboard sb;
  bit quiet;
  int written[$];
  int stall_left;
  int idle_cycles;

  vertex_normal_accumulator u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic logic [95:0] pack_word(cmd_t c, int idx, int x, int y, int z,
                                            int a, int b, int f);
    logic [95:0] d;
    d = '0;
    d[1:0] = c;
    d[11:2] = idx[9:0];
    d[27:12] = x[15:0];
    d[43:28] = y[15:0];
    d[59:44] = z[15:0];
    d[69:60] = a[9:0];
    d[79:70] = b[9:0];
    d[89:80] = f[9:0];
    return d;
  endfunction

  task automatic send_word(logic [95:0] d);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
    sb.note_word(d);
  endtask

  task automatic put_vertex(int idx, int x, int y, int z);
    send_word(pack_word(CMD_WRITE_VERTEX, idx, x, y, z, 0, 0, 0));
    written.push_back(idx);
  endtask

  task automatic put_face(int a, int b, int f);
    send_word(pack_word(CMD_ADD_FACE, 0, 0, 0, 0, a, b, f));
  endtask

  task automatic get_normal(int idx);
    send_word(pack_word(CMD_READ_NORMAL, idx, 0, 0, 0, 0, 0, 0));
  endtask

  // result side with random stall bursts outside the quiet phase
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_word(m_tdata);
    if (quiet) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 9) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    int op, n, x, y, z;
    sb = new();
    quiet = 1'b0;
    stall_left = 0;
    idle_cycles = 0;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    m_tready <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    put_vertex(0, 0, 0, 0);
    put_vertex(1, 256, 0, 0);
    put_vertex(2, 0, 256, 0);
    put_face(0, 1, 2);
    put_face(0, 2, 1);          // opposite winding sums to zero
    get_normal(0);
    put_face(0, 1, 2);
    put_face(0, 1, 2);
    get_normal(1);
    put_vertex(1021, -32768, -32768, -32768);
    put_vertex(1022, 32767, -32768, 32767);
    put_vertex(1023, -32768, 32767, 32767);
    put_face(1021, 1022, 1023);
    get_normal(1023);
    get_normal(1022);
    put_vertex(3, 512, 0, 0);
    put_face(0, 1, 3);          // collinear corners
    put_face(1, 1, 2);          // repeated corner
    send_word({6'd0, {90{1'b1}}});
    send_word('0 | CMD_NONE);
    get_normal(500);            // never touched

    for (int k = 0; k < RANDOM_WORDS; k++) begin
      if (k == QUIET_FROM) quiet = 1'b1;
      op = $urandom_range(0, 99);
      if (op < 30 || written.size() < 3) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, NVERT - 1) : $urandom_range(0, 15);
        if ($urandom_range(0, 4) == 0) begin
          x = $urandom; y = $urandom; z = $urandom;
        end else begin
          x = $urandom_range(0, 4095) - 2048;
          y = $urandom_range(0, 4095) - 2048;
          z = $urandom_range(0, 4095) - 2048;
        end
        put_vertex(n, x, y, z);
      end else if (op < 75) begin
        x = written[$urandom_range(0, written.size() - 1)];
        y = written[$urandom_range(0, written.size() - 1)];
        z = ($urandom_range(0, 9) == 0) ? x : written[$urandom_range(0, written.size() - 1)];
        put_face(x, y, z);
      end else if (op < 95) begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NVERT - 1) :
            written[$urandom_range(0, written.size() - 1)];
        get_normal(n);
      end else begin
        send_word({$urandom, $urandom, $urandom} | CMD_NONE);
      end
    end
    s_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
